### hw/rtl/clcd_pkg.sv
// Shared types, constants and the control store for the command line decoder.
// Depends on nothing; every other file uses it by scoped names.
`default_nettype none
package clcd_pkg;

   localparam int LINE_CHARS_DEF = 19;
   localparam int KEYWORD_COUNT  = 11;
   localparam int KEY_MAX_LEN    = 11;
   localparam int KEY_IDX_W      = 4;

   localparam int CHAR_W  = 8;
   localparam int LAMP_W  = 3;
   localparam int SERVO_W = 11;
   localparam int CODE_W  = 4;
   localparam int STEP_W  = 3;

   localparam logic [CHAR_W-1:0] CHAR_LF = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;
   localparam logic [CHAR_W-1:0] NUL     = 8'h00;

   localparam int                 SERVO_SPAN  = 2000;
   localparam logic [SERVO_W-1:0] SERVO_OPEN  = 11'd500;
   localparam logic [SERVO_W-1:0] SERVO_CLOSE = SERVO_OPEN + SERVO_W'(SERVO_SPAN / 2);

   localparam logic [CODE_W-1:0] CODE_NONE     = 4'd0;
   localparam logic [CODE_W-1:0] CODE_OPEN     = 4'd1;
   localparam logic [CODE_W-1:0] CODE_CLOSE    = 4'd2;
   localparam logic [CODE_W-1:0] CODE_FLOOR1   = 4'd3;
   localparam logic [CODE_W-1:0] CODE_ALL_ON   = 4'd4;
   localparam logic [CODE_W-1:0] CODE_ALL_OFF  = 4'd5;
   localparam logic [CODE_W-1:0] CODE_LED1_ON  = 4'd6;
   localparam logic [CODE_W-1:0] CODE_LED1_OFF = 4'd7;
   localparam logic [CODE_W-1:0] CODE_LED2_ON  = 4'd8;
   localparam logic [CODE_W-1:0] CODE_LED2_OFF = 4'd9;
   localparam logic [CODE_W-1:0] CODE_LED3_ON  = 4'd10;
   localparam logic [CODE_W-1:0] CODE_LED3_OFF = 4'd11;
   localparam logic [CODE_W-1:0] CODE_UNKNOWN  = 4'd12;

   // keyword k carries command code k + 1
   localparam logic [CHAR_W-1:0] KW_TEXT [KEYWORD_COUNT][KEY_MAX_LEN] = '{
      '{"O", "P", "E", "N", NUL, NUL, NUL, NUL, NUL, NUL, NUL},
      '{"C", "L", "O", "S", "E", NUL, NUL, NUL, NUL, NUL, NUL},
      '{"F", "L", "O", "O", "R", "1", "_", "O", "N", "L", "Y"},
      '{"A", "L", "L", "_", "O", "N", NUL, NUL, NUL, NUL, NUL},
      '{"A", "L", "L", "_", "O", "F", "F", NUL, NUL, NUL, NUL},
      '{"L", "E", "D", "1", "_", "O", "N", NUL, NUL, NUL, NUL},
      '{"L", "E", "D", "1", "_", "O", "F", "F", NUL, NUL, NUL},
      '{"L", "E", "D", "2", "_", "O", "N", NUL, NUL, NUL, NUL},
      '{"L", "E", "D", "2", "_", "O", "F", "F", NUL, NUL, NUL},
      '{"L", "E", "D", "3", "_", "O", "N", NUL, NUL, NUL, NUL},
      '{"L", "E", "D", "3", "_", "O", "F", "F", NUL, NUL, NUL}
   };

   localparam logic [KEY_IDX_W-1:0] KW_LEN [KEYWORD_COUNT] = '{
      4'd4, 4'd5, 4'd11, 4'd6, 4'd7, 4'd7, 4'd8, 4'd7, 4'd8, 4'd7, 4'd8
   };

   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_TAKE  = 3'd1,
      ACT_STORE = 3'd2,
      ACT_INIT  = 3'd3,
      ACT_CMP   = 3'd4,
      ACT_APPLY = 3'd5
   } act_type;

   typedef enum logic [2:0] {
      COND_NEXT     = 3'd0,
      COND_ALWAYS   = 3'd1,
      COND_NO_REQ   = 3'd2,
      COND_TERM     = 3'd3,
      COND_LEN_ZERO = 3'd4,
      COND_NOT_LAST = 3'd5
   } cond_type;

   localparam logic [STEP_W-1:0] STEP_WAIT     = 3'd0;
   localparam logic [STEP_W-1:0] STEP_CLASSIFY = 3'd1;
   localparam logic [STEP_W-1:0] STEP_STORE    = 3'd2;
   localparam logic [STEP_W-1:0] STEP_INIT     = 3'd3;
   localparam logic [STEP_W-1:0] STEP_CMP      = 3'd4;
   localparam logic [STEP_W-1:0] STEP_APPLY    = 3'd5;

   typedef struct packed {
      act_type             act;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
      logic                emit;
   } ucode_type;

   typedef struct packed {
      act_type act;
      logic    fire;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic term;
      logic len_zero;
      logic last_char;
      logic out_busy;
   } stat_type;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      case (step)
         STEP_WAIT:     w = '{ACT_TAKE,  COND_NO_REQ,   STEP_WAIT,  1'b0};
         STEP_CLASSIFY: w = '{ACT_NONE,  COND_TERM,     STEP_INIT,  1'b0};
         STEP_STORE:    w = '{ACT_STORE, COND_ALWAYS,   STEP_WAIT,  1'b1};
         STEP_INIT:     w = '{ACT_INIT,  COND_LEN_ZERO, STEP_APPLY, 1'b0};
         STEP_CMP:      w = '{ACT_CMP,   COND_NOT_LAST, STEP_CMP,   1'b0};
         STEP_APPLY:    w = '{ACT_APPLY, COND_ALWAYS,   STEP_WAIT,  1'b1};
         default:       w = '{ACT_NONE,  COND_ALWAYS,   STEP_WAIT,  1'b0};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/ascii_command_line_decoder.sv
// An ordinary byte gives its word via the wait, classify and store steps; a line
// end goes via wait, classify, init, a compare loop over min(length, 11) stored
// characters, one read per cycle and skipped for an empty line, then apply. A new
// byte is taken only in wait, after the last word is registered.
// Reset: synchronous, active high; lamps off, servo at 500, line empty.
`default_nettype none
module ascii_command_line_decoder #(
   parameter int LINE_CHARS = clcd_pkg::LINE_CHARS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [clcd_pkg::CHAR_W-1:0]   req_rx_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [clcd_pkg::LAMP_W-1:0]   rsp_lamp_bits,
   output logic      [clcd_pkg::SERVO_W-1:0]  rsp_servo_compare,
   output logic                               rsp_line_ended,
   output logic      [clcd_pkg::CODE_W-1:0]   rsp_command_code
);

   clcd_pkg::ctrl_type ctrl;
   clcd_pkg::stat_type stat;

   clcd_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   clcd_exec #(
      .LINE_CHARS (LINE_CHARS)
   ) u_exec (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .stat              (stat),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_lamp_bits     (rsp_lamp_bits),
      .rsp_servo_compare (rsp_servo_compare),
      .rsp_line_ended    (rsp_line_ended),
      .rsp_command_code  (rsp_command_code)
   );

endmodule
`default_nettype wire

### hw/rtl/clcd_line_mem.sv
// Line character store: one write port, one registered read port.
// Depends on clcd_pkg for the character width and the default depth.
`default_nettype none
module clcd_line_mem #(
   parameter int DEPTH = clcd_pkg::LINE_CHARS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  wire logic [clcd_pkg::CHAR_W-1:0]  wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic      [clcd_pkg::CHAR_W-1:0]  rd_data
);

   logic [clcd_pkg::CHAR_W-1:0] mem_ff [DEPTH];
   logic [clcd_pkg::CHAR_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule
`default_nettype wire

### hw/rtl/clcd_exec.sv
// Datapath: byte capture, line length, keyword match bits, lamp and servo state,
// result register. Depends on clcd_pkg and clcd_line_mem.
`default_nettype none
module clcd_exec #(
   parameter int LINE_CHARS = clcd_pkg::LINE_CHARS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire clcd_pkg::ctrl_type            ctrl,
   output clcd_pkg::stat_type                 stat,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [clcd_pkg::CHAR_W-1:0]   req_rx_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [clcd_pkg::LAMP_W-1:0]   rsp_lamp_bits,
   output logic      [clcd_pkg::SERVO_W-1:0]  rsp_servo_compare,
   output logic                               rsp_line_ended,
   output logic      [clcd_pkg::CODE_W-1:0]   rsp_command_code
);

   localparam int IDX_W = $clog2(LINE_CHARS);
   localparam int LEN_W = $clog2(LINE_CHARS + 1);

   logic [clcd_pkg::CHAR_W-1:0]        byte_ff;
   logic [LEN_W-1:0]                   len_ff, len_in;
   logic [IDX_W-1:0]                   idx_ff, idx_in;
   logic [clcd_pkg::KEYWORD_COUNT-1:0] match_ff, match_in;
   logic [clcd_pkg::LAMP_W-1:0]        lamp_ff, lamp_in;
   logic [clcd_pkg::SERVO_W-1:0]       servo_ff, servo_in;
   logic                               rsp_valid_ff;
   logic [clcd_pkg::LAMP_W-1:0]        rsp_lamp_ff;
   logic [clcd_pkg::SERVO_W-1:0]       rsp_servo_ff;
   logic                               rsp_ended_ff;
   logic [clcd_pkg::CODE_W-1:0]        rsp_code_ff;
   logic [clcd_pkg::CODE_W-1:0]        code;
   logic                               mem_we;
   logic [IDX_W-1:0]                   mem_raddr;
   logic [clcd_pkg::CHAR_W-1:0]        mem_rdata;
   logic                               take, emit;

   assign req_stall = (ctrl.act != clcd_pkg::ACT_TAKE);
   assign take      = ctrl.fire && (ctrl.act == clcd_pkg::ACT_TAKE) && req_valid;
   assign emit      = ctrl.fire &&
                      (ctrl.act == clcd_pkg::ACT_STORE || ctrl.act == clcd_pkg::ACT_APPLY);

   assign stat.req_valid = req_valid;
   assign stat.term      = (byte_ff == clcd_pkg::CHAR_LF) || (byte_ff == clcd_pkg::CHAR_CR);
   assign stat.len_zero  = (len_ff == '0);
   assign stat.last_char = (idx_ff == IDX_W'(clcd_pkg::KEY_MAX_LEN - 1)) ||
                           ((LEN_W'(idx_ff) + LEN_W'(1)) == len_ff);
   assign stat.out_busy  = rsp_valid_ff && rsp_stall;

   assign mem_we = ctrl.fire && (ctrl.act == clcd_pkg::ACT_STORE) &&
                   (len_ff < LEN_W'(LINE_CHARS));

   always_comb begin
      if (ctrl.act == clcd_pkg::ACT_CMP && !stat.last_char) begin
         mem_raddr = idx_ff + IDX_W'(1);
      end else begin
         mem_raddr = '0;
      end
   end

   clcd_line_mem #(
      .DEPTH (LINE_CHARS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (len_ff[IDX_W-1:0]),
      .wr_data (byte_ff),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      code = clcd_pkg::CODE_UNKNOWN;
      for (int k = clcd_pkg::KEYWORD_COUNT - 1; k >= 0; k--) begin
         if (match_ff[k]) begin
            code = clcd_pkg::CODE_W'(k + 1);
         end
      end
      if (len_ff == '0) begin
         code = clcd_pkg::CODE_NONE;
      end
   end

   always_comb begin
      lamp_in  = lamp_ff;
      servo_in = servo_ff;
      case (code)
         clcd_pkg::CODE_OPEN:     servo_in = clcd_pkg::SERVO_OPEN;
         clcd_pkg::CODE_CLOSE:    servo_in = clcd_pkg::SERVO_CLOSE;
         clcd_pkg::CODE_FLOOR1:   lamp_in  = 3'b001;
         clcd_pkg::CODE_ALL_ON:   lamp_in  = 3'b111;
         clcd_pkg::CODE_ALL_OFF:  lamp_in  = 3'b000;
         clcd_pkg::CODE_LED1_ON:  lamp_in  = lamp_ff | 3'b001;
         clcd_pkg::CODE_LED1_OFF: lamp_in  = lamp_ff & 3'b110;
         clcd_pkg::CODE_LED2_ON:  lamp_in  = lamp_ff | 3'b010;
         clcd_pkg::CODE_LED2_OFF: lamp_in  = lamp_ff & 3'b101;
         clcd_pkg::CODE_LED3_ON:  lamp_in  = lamp_ff | 3'b100;
         clcd_pkg::CODE_LED3_OFF: lamp_in  = lamp_ff & 3'b011;
         default: begin
            lamp_in  = lamp_ff;
            servo_in = servo_ff;
         end
      endcase
   end

   always_comb begin
      len_in   = len_ff;
      idx_in   = idx_ff;
      match_in = match_ff;
      if (ctrl.fire) begin
         case (ctrl.act)
            clcd_pkg::ACT_STORE: begin
               if (len_ff < LEN_W'(LINE_CHARS)) begin
                  len_in = len_ff + LEN_W'(1);
               end
            end
            clcd_pkg::ACT_INIT: begin
               idx_in = '0;
               for (int k = 0; k < clcd_pkg::KEYWORD_COUNT; k++) begin
                  match_in[k] = (LEN_W'(clcd_pkg::KW_LEN[k]) == len_ff);
               end
            end
            clcd_pkg::ACT_CMP: begin
               idx_in = idx_ff + IDX_W'(1);
               for (int k = 0; k < clcd_pkg::KEYWORD_COUNT; k++) begin
                  match_in[k] = match_ff[k] &&
                     (mem_rdata == clcd_pkg::KW_TEXT[k][idx_ff[clcd_pkg::KEY_IDX_W-1:0]]);
               end
            end
            clcd_pkg::ACT_APPLY: len_in = '0;
            default: begin
               len_in = len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         lamp_ff      <= '0;
         servo_ff     <= clcd_pkg::SERVO_OPEN;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         if (ctrl.fire && ctrl.act == clcd_pkg::ACT_APPLY) begin
            lamp_ff  <= lamp_in;
            servo_ff <= servo_in;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      match_ff <= match_in;
      if (take) begin
         byte_ff <= req_rx_byte;
      end
      if (emit) begin
         if (ctrl.act == clcd_pkg::ACT_APPLY) begin
            rsp_lamp_ff  <= lamp_in;
            rsp_servo_ff <= servo_in;
            rsp_ended_ff <= 1'b1;
            rsp_code_ff  <= code;
         end else begin
            rsp_lamp_ff  <= lamp_ff;
            rsp_servo_ff <= servo_ff;
            rsp_ended_ff <= 1'b0;
            rsp_code_ff  <= clcd_pkg::CODE_NONE;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_lamp_bits     = rsp_lamp_ff;
   assign rsp_servo_compare = rsp_servo_ff;
   assign rsp_line_ended    = rsp_ended_ff;
   assign rsp_command_code  = rsp_code_ff;

endmodule
`default_nettype wire

### hw/rtl/clcd_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on clcd_pkg for the control word format and the program.
`default_nettype none
module clcd_seq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire clcd_pkg::stat_type stat,
   output clcd_pkg::ctrl_type      ctrl
);

   logic [clcd_pkg::STEP_W-1:0] step_ff, step_in;
   clcd_pkg::ucode_type         uw;
   logic                        hold;
   logic                        jump;

   assign uw   = clcd_pkg::ucode_rom(step_ff);
   assign hold = uw.emit && stat.out_busy;

   always_comb begin
      case (uw.cond)
         clcd_pkg::COND_ALWAYS:   jump = 1'b1;
         clcd_pkg::COND_NO_REQ:   jump = !stat.req_valid;
         clcd_pkg::COND_TERM:     jump = stat.term;
         clcd_pkg::COND_LEN_ZERO: jump = stat.len_zero;
         clcd_pkg::COND_NOT_LAST: jump = !stat.last_char;
         default:                 jump = 1'b0;
      endcase
   end

   always_comb begin
      if (hold) begin
         step_in = step_ff;
      end else if (jump) begin
         step_in = uw.target;
      end else begin
         step_in = step_ff + clcd_pkg::STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= clcd_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl.act  = uw.act;
   assign ctrl.fire = !hold;

endmodule
`default_nettype wire

### hw/rtl/clcd_checker.sv
// Port-level checks for the command line decoder, bound to the top level.
// Depends on clcd_pkg and ascii_command_line_decoder.
`default_nettype none
module clcd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic [clcd_pkg::CHAR_W-1:0]   req_rx_byte,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [clcd_pkg::LAMP_W-1:0]   rsp_lamp_bits,
   input wire logic [clcd_pkg::SERVO_W-1:0]  rsp_servo_compare,
   input wire logic                          rsp_line_ended,
   input wire logic [clcd_pkg::CODE_W-1:0]   rsp_command_code
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_command_code) &&
      $stable(rsp_lamp_bits) && $stable(rsp_servo_compare))
      else $error("result word changed while stalled");

   a_no_code_mid_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_line_ended |-> rsp_command_code == clcd_pkg::CODE_NONE)
      else $error("command reported without line end");

   a_servo_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_servo_compare == clcd_pkg::SERVO_OPEN ||
                    rsp_servo_compare == clcd_pkg::SERVO_CLOSE)
      else $error("servo value outside open and close");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_command_code <= clcd_pkg::CODE_UNKNOWN)
      else $error("command code out of range");

   a_open_servo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_code == clcd_pkg::CODE_OPEN |->
      rsp_servo_compare == clcd_pkg::SERVO_OPEN)
      else $error("open did not set servo");

endmodule

bind ascii_command_line_decoder clcd_checker u_clcd_checker (.*);
`default_nettype wire

### verif/tb_ascii_command_line_decoder.sv
// Self-checking testbench for ascii_command_line_decoder: keyword lines, noise and
// overlong lines go in, every word out is checked against a line decoder predictor.
// Depends on clcd_pkg and the decoder RTL only.
`timescale 1ns / 100ps
module tb_ascii_command_line_decoder;

   localparam int LINE_LIMIT   = clcd_pkg::LINE_CHARS_DEF;
   localparam int RANDOM_BYTES = 1250;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 40;

   typedef struct {
      logic [clcd_pkg::LAMP_W-1:0]  lamps;
      logic [clcd_pkg::SERVO_W-1:0] servo;
      logic                         ended;
      logic [clcd_pkg::CODE_W-1:0]  code;
   } line_word_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid   = 1'b0;
   logic                          req_stall;
   logic [clcd_pkg::CHAR_W-1:0]   req_rx_byte = '0;
   logic                          rsp_valid;
   logic                          rsp_stall   = 1'b0;
   logic [clcd_pkg::LAMP_W-1:0]   rsp_lamp_bits;
   logic [clcd_pkg::SERVO_W-1:0]  rsp_servo_compare;
   logic                          rsp_line_ended;
   logic [clcd_pkg::CODE_W-1:0]   rsp_command_code;

   string keyword_text [clcd_pkg::KEYWORD_COUNT];
   logic [clcd_pkg::CODE_W-1:0] keyword_code [clcd_pkg::KEYWORD_COUNT] = '{
      clcd_pkg::CODE_OPEN, clcd_pkg::CODE_CLOSE, clcd_pkg::CODE_FLOOR1,
      clcd_pkg::CODE_ALL_ON, clcd_pkg::CODE_ALL_OFF, clcd_pkg::CODE_LED1_ON,
      clcd_pkg::CODE_LED1_OFF, clcd_pkg::CODE_LED2_ON, clcd_pkg::CODE_LED2_OFF,
      clcd_pkg::CODE_LED3_ON, clcd_pkg::CODE_LED3_OFF
   };

   logic [clcd_pkg::CHAR_W-1:0]  pending_bytes [$];
   line_word_type                expected_words [$];

   logic [clcd_pkg::CHAR_W-1:0]  line_buf [LINE_LIMIT];
   int                           line_len = 0;
   logic [clcd_pkg::LAMP_W-1:0]  lamps_now = '0;
   logic [clcd_pkg::SERVO_W-1:0] servo_now = clcd_pkg::SERVO_OPEN;

   int error_count = 0;
   int word_count  = 0;
   int cycle_count = 0;
   int drv_wait    = 0;
   int drv_calm    = 0;
   int rsp_wait    = 0;
   int rsp_calm    = 0;
   line_word_type want;

   ascii_command_line_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_lamp_bits     (rsp_lamp_bits),
      .rsp_servo_compare (rsp_servo_compare),
      .rsp_line_ended    (rsp_line_ended),
      .rsp_command_code  (rsp_command_code)
   );

   function automatic string kw_text(input int k);
      string s;
      s = "";
      for (int i = 0; i < int'(clcd_pkg::KW_LEN[k]); i++)
         s = $sformatf("%s%c", s, clcd_pkg::KW_TEXT[k][i]);
      return s;
   endfunction

   function automatic logic [clcd_pkg::CODE_W-1:0] match_line();
      logic hit;
      if (line_len == 0) return clcd_pkg::CODE_NONE;
      for (int k = 0; k < clcd_pkg::KEYWORD_COUNT; k++) begin
         if (keyword_text[k].len() == line_len) begin
            hit = 1'b1;
            for (int i = 0; i < line_len; i++) begin
               if (line_buf[i] != keyword_text[k][i]) hit = 1'b0;
            end
            if (hit) return keyword_code[k];
         end
      end
      return clcd_pkg::CODE_UNKNOWN;
   endfunction

   function automatic void decode_byte(input logic [clcd_pkg::CHAR_W-1:0] ch);
      line_word_type w;
      w.ended = 1'b0;
      w.code  = clcd_pkg::CODE_NONE;
      if (ch == clcd_pkg::CHAR_LF || ch == clcd_pkg::CHAR_CR) begin
         w.ended = 1'b1;
         w.code  = match_line();
         case (w.code)
            clcd_pkg::CODE_OPEN:     servo_now = clcd_pkg::SERVO_OPEN;
            clcd_pkg::CODE_CLOSE:    servo_now = clcd_pkg::SERVO_CLOSE;
            clcd_pkg::CODE_FLOOR1:   lamps_now = 3'b001;
            clcd_pkg::CODE_ALL_ON:   lamps_now = 3'b111;
            clcd_pkg::CODE_ALL_OFF:  lamps_now = 3'b000;
            clcd_pkg::CODE_LED1_ON:  lamps_now[0] = 1'b1;
            clcd_pkg::CODE_LED1_OFF: lamps_now[0] = 1'b0;
            clcd_pkg::CODE_LED2_ON:  lamps_now[1] = 1'b1;
            clcd_pkg::CODE_LED2_OFF: lamps_now[1] = 1'b0;
            clcd_pkg::CODE_LED3_ON:  lamps_now[2] = 1'b1;
            clcd_pkg::CODE_LED3_OFF: lamps_now[2] = 1'b0;
            default: ;
         endcase
         line_len = 0;
      end else if (line_len < LINE_LIMIT) begin
         line_buf[line_len] = ch;
         line_len++;
      end
      w.lamps = lamps_now;
      w.servo = servo_now;
      expected_words.push_back(w);
   endfunction

   function automatic int draw_gap(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 40);
      return $urandom_range(0, 6);
   endfunction

   function automatic logic [clcd_pkg::CHAR_W-1:0] plain_char();
      logic [clcd_pkg::CHAR_W-1:0] b;
      do b = clcd_pkg::CHAR_W'($urandom_range(0, 255));
      while (b == clcd_pkg::CHAR_LF || b == clcd_pkg::CHAR_CR);
      return b;
   endfunction

   function automatic logic [clcd_pkg::CHAR_W-1:0] line_end();
      return $urandom_range(0, 1) ? clcd_pkg::CHAR_CR : clcd_pkg::CHAR_LF;
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("word %0d: %s", word_count, msg);
      error_count++;
   endtask

   function automatic void push_random_line();
      string kw;
      int dice, n;
      kw   = keyword_text[$urandom_range(0, clcd_pkg::KEYWORD_COUNT - 1)];
      dice = $urandom_range(0, 99);
      if (dice < 60) begin
         push_text(kw);
      end else if (dice < 70) begin
         n = $urandom_range(0, kw.len() - 1);
         for (int i = 0; i < kw.len(); i++)
            pending_bytes.push_back(i == n ? plain_char() : clcd_pkg::CHAR_W'(kw[i]));
      end else if (dice < 76) begin
         if ($urandom_range(0, 1)) begin
            push_text(kw.substr(0, kw.len() - 2));
         end else begin
            push_text(kw);
            pending_bytes.push_back(plain_char());
         end
      end else if (dice < 82) begin
      end else if (dice < 90) begin
         n = $urandom_range(1, 8);
         repeat (n) pending_bytes.push_back(plain_char());
      end else if (dice < 96) begin
         n = $urandom_range(LINE_LIMIT - 1, LINE_LIMIT + 9);
         if ($urandom_range(0, 1)) begin
            push_text(kw);
            n -= kw.len();
         end
         repeat (n) pending_bytes.push_back(plain_char());
      end else begin
         push_text(kw);
         pending_bytes.push_back(clcd_pkg::NUL);
      end
      pending_bytes.push_back(line_end());
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // driver: hold while stalled, then advance to the next pending byte after a gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_rx_byte <= '0;
         drv_wait = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) decode_byte(req_rx_byte);
         if (drv_wait > 0) begin
            req_valid <= 1'b0;
            drv_wait--;
         end else if (pending_bytes.size() > 0) begin
            req_valid   <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
            drv_wait = draw_gap(drv_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: check each accepted word against the oldest expected one
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("word with nothing expected");
            end else begin
               want = expected_words.pop_front();
               if (rsp_lamp_bits !== want.lamps)
                  report_mismatch($sformatf("lamp_bits %0d, expected %0d",
                                            rsp_lamp_bits, want.lamps));
               if (rsp_servo_compare !== want.servo)
                  report_mismatch($sformatf("servo_compare %0d, expected %0d",
                                            rsp_servo_compare, want.servo));
               if (rsp_line_ended !== want.ended)
                  report_mismatch($sformatf("line_ended %0d, expected %0d",
                                            rsp_line_ended, want.ended));
               if (rsp_command_code !== want.code)
                  report_mismatch($sformatf("command_code %0d, expected %0d",
                                            rsp_command_code, want.code));
            end
            word_count++;
            rsp_wait = draw_gap(rsp_calm);
         end
         if (rsp_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      reset = 1'b1;
      for (int k = 0; k < clcd_pkg::KEYWORD_COUNT; k++) keyword_text[k] = kw_text(k);
      push_text("CLOSE");
      pending_bytes.push_back(clcd_pkg::CHAR_CR);
      push_text("OPEN");
      pending_bytes.push_back(clcd_pkg::CHAR_LF);
      pending_bytes.push_back(clcd_pkg::CHAR_CR);
      pending_bytes.push_back(clcd_pkg::NUL);
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(clcd_pkg::CHAR_LF);
      push_text("ALL_ON");
      pending_bytes.push_back(clcd_pkg::CHAR_CR);
      while (pending_bytes.size() < RANDOM_BYTES) push_random_line();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (pending_bytes.size() > 0 || req_valid || expected_words.size() > 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_words.size() > 0)
         report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/clcd_pkg.sv
hw/rtl/clcd_line_mem.sv
hw/rtl/clcd_exec.sv
hw/rtl/clcd_seq.sv
hw/rtl/ascii_command_line_decoder.sv
hw/rtl/clcd_checker.sv
verif/tb_ascii_command_line_decoder.sv
